[hw/rtl/polygon_plane_splitter_core_defines.svh]
// assertion macros for the polygon plane splitter checker
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef POLYGON_PLANE_SPLITTER_CORE_DEFINES_SVH
`define POLYGON_PLANE_SPLITTER_CORE_DEFINES_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pps_pkg.sv]
// shared widths, types and helpers of the polygon plane splitter
// no dependencies
package pps_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int NORM_W     = 18;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD1_W    = NORM_W + COORD_W;
    localparam int DSUM_W     = PROD1_W + 2;
    localparam int DIST_W     = DSUM_W - FRAC_W + 1;
    localparam int MAG_W      = DIST_W;
    localparam int SUM_W      = MAG_W + 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + MAG_W;
    localparam int CNT_W      = $clog2(DIFF_W);
    localparam int Q_DEPTH    = 4;
    localparam int QPTR_W     = $clog2(Q_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X = 3'd0,
        CFG_NORMAL_Y = 3'd1,
        CFG_NORMAL_Z = 3'd2,
        CFG_OFFSET   = 3'd3,
        CFG_TOL      = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VERDICT_SPLIT    = 2'd0,
        VERDICT_COPLANAR = 2'd1,
        VERDICT_BELOW    = 2'd2,
        VERDICT_ABOVE    = 2'd3
    } t_verdict;

    typedef struct packed {
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_z;
        logic signed [COORD_W-1:0] plane_offset;
        logic [TOL_W-1:0]          tol;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [DIST_W-1:0]  plane_dist;
        logic                      final_vertex;
    } t_vert_rec;

    // magnitude of a distance
    function automatic logic [MAG_W-1:0] dist_mag(input logic signed [DIST_W-1:0] d);
        logic [MAG_W-1:0] r;
        r = d[DIST_W-1] ? MAG_W'(-d) : MAG_W'(d);
        return r;
    endfunction

    // edge ends strictly on opposite sides, both with magnitude above the tolerance
    function automatic logic crosses(input logic signed [DIST_W-1:0] da,
                                     input logic signed [DIST_W-1:0] db,
                                     input logic [TOL_W-1:0] tol);
        logic opp;
        opp = (da < 0 && db > 0) || (da > 0 && db < 0);
        return opp && (dist_mag(da) > MAG_W'(tol)) && (dist_mag(db) > MAG_W'(tol));
    endfunction

endpackage

[hw/rtl/pps_vert_if.sv]
// input channel carrying one polygon vertex per word
// depends on pps_pkg
interface pps_vert_if;
    import pps_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vert_x;
    logic signed [COORD_W-1:0] vert_y;
    logic signed [COORD_W-1:0] vert_z;
    logic                      final_vertex;

    modport source(output valid, vert_x, vert_y, vert_z, final_vertex, input ready);
    modport sink(input valid, vert_x, vert_y, vert_z, final_vertex, output ready);
endinterface

[hw/rtl/pps_point_if.sv]
// output channel carrying one emitted point or verdict per word
// depends on pps_pkg
interface pps_point_if;
    import pps_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      goes_below;
    logic                      goes_above;
    logic                      is_crossing;
    logic                      end_of_polygon;
    logic [1:0]                verdict;

    modport source(output valid, out_x, out_y, out_z, goes_below, goes_above,
                   is_crossing, end_of_polygon, verdict, input ready);
    modport sink(input valid, out_x, out_y, out_z, goes_below, goes_above,
                 is_crossing, end_of_polygon, verdict, output ready);
endinterface

[hw/rtl/pps_front.sv]
// front end: accepts vertices and computes the signed plane distance
// depends on pps_pkg and pps_vert_if
module pps_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pps_pkg::t_cfg     i_cfg,
    pps_vert_if.sink          i_vert,
    output logic              o_push,
    output pps_pkg::t_vert_rec o_rec,
    input  logic              i_full
);
    import pps_pkg::*;

    logic                      r_p_valid;
    logic                      r_d_valid;
    logic signed [PROD1_W-1:0] r_prod_x;
    logic signed [PROD1_W-1:0] r_prod_y;
    logic signed [PROD1_W-1:0] r_prod_z;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic signed [COORD_W-1:0] r_pz;
    logic                      r_pfinal;
    t_vert_rec                 r_rec;
    logic                      accept;
    logic                      p_move;
    logic signed [DSUM_W-1:0]  dsum;
    logic signed [DSUM_W-1:0]  dshift;
    logic signed [DIST_W-1:0]  vdist;

    assign i_vert.ready = !r_p_valid;
    assign accept       = i_vert.valid && !r_p_valid;
    assign o_push       = r_d_valid && !i_full;
    assign p_move       = r_p_valid && (!r_d_valid || o_push);
    assign o_rec        = r_rec;

    // sum of products, floor shift, then the plane offset
    always_comb begin
        dsum   = DSUM_W'(r_prod_x) + DSUM_W'(r_prod_y) + DSUM_W'(r_prod_z);
        dshift = dsum >>> FRAC_W;
        vdist  = DIST_W'(dshift) + DIST_W'(i_cfg.plane_offset);
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_d_valid <= 1'b1;
            end else if (o_push) begin
                r_d_valid <= 1'b0;
            end
        end
    end

    // product stage and distance stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_x <= PROD1_W'(i_cfg.normal_x) * PROD1_W'(i_vert.vert_x);
            r_prod_y <= PROD1_W'(i_cfg.normal_y) * PROD1_W'(i_vert.vert_y);
            r_prod_z <= PROD1_W'(i_cfg.normal_z) * PROD1_W'(i_vert.vert_z);
            r_px     <= i_vert.vert_x;
            r_py     <= i_vert.vert_y;
            r_pz     <= i_vert.vert_z;
            r_pfinal <= i_vert.final_vertex;
        end
        if (p_move) begin
            r_rec.x            <= r_px;
            r_rec.y            <= r_py;
            r_rec.z            <= r_pz;
            r_rec.plane_dist   <= vdist;
            r_rec.final_vertex <= r_pfinal;
        end
    end
endmodule

[hw/rtl/pps_queue.sv]
// short queue of classified vertices between front and back
// depends on pps_pkg
module pps_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pps_pkg::t_vert_rec i_rec,
    output logic               o_full,
    input  logic               i_pop,
    output pps_pkg::t_vert_rec o_rec,
    output logic               o_empty
);
    import pps_pkg::*;

    t_vert_rec         r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end
endmodule

[hw/rtl/pps_back.sv]
// back end: edge crossings by serial multiply and divide, result emission
// depends on pps_pkg and pps_point_if
module pps_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [pps_pkg::TOL_W-1:0] i_tol,
    input  pps_pkg::t_vert_rec i_rec,
    input  logic               i_empty,
    output logic               o_pop,
    pps_point_if.source        o_point
);
    import pps_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_PLAN  = 11'b000_0000_0010,
        S_SETUP = 11'b000_0000_0100,
        S_MUL   = 11'b000_0000_1000,
        S_DLOAD = 11'b000_0001_0000,
        S_DIV   = 11'b000_0010_0000,
        S_RND   = 11'b000_0100_0000,
        S_EMITX = 11'b000_1000_0000,
        S_VERT  = 11'b001_0000_0000,
        S_CLOSE = 11'b010_0000_0000,
        S_END   = 11'b100_0000_0000
    } t_state;

    t_state                    r_state;
    t_vert_rec                 r_cur;
    logic signed [COORD_W-1:0] r_prior [3];
    logic signed [COORD_W-1:0] r_first [3];
    logic signed [DIST_W-1:0]  r_prior_dist;
    logic signed [DIST_W-1:0]  r_first_dist;
    logic                      r_seen;
    logic                      r_any_b;
    logic                      r_any_a;
    logic                      r_closing;
    logic [1:0]                r_lane;
    logic [CNT_W-1:0]          r_cnt;
    logic [DIFF_W-1:0]         r_m;
    logic                      r_up;
    logic [PROD_W-1:0]         r_p;
    logic [SUM_W-1:0]          r_rem;
    logic [DIFF_W-1:0]         r_q;
    logic signed [COORD_W-1:0] r_cp [3];
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_ox;
    logic signed [COORD_W-1:0] r_oy;
    logic signed [COORD_W-1:0] r_oz;
    logic                      r_obelow;
    logic                      r_oabove;
    logic                      r_ocross;
    logic                      r_oend;
    t_verdict                  r_overdict;

    logic                      out_free;
    logic                      emit;
    logic signed [COORD_W-1:0] cur_c;
    logic signed [COORD_W-1:0] prior_c;
    logic signed [COORD_W-1:0] first_c;
    logic signed [COORD_W-1:0] a_c;
    logic signed [COORD_W-1:0] b_c;
    logic signed [DIST_W-1:0]  da;
    logic signed [DIST_W-1:0]  db;
    logic [MAG_W-1:0]          f;
    logic [SUM_W-1:0]          s;
    logic signed [DIFF_W-1:0]  diff;
    logic [SUM_W:0]            trial;
    logic                      ge;
    logic                      rnd;
    logic [DIFF_W-1:0]         qr;
    logic signed [COORD_W-1:0] cross_c;
    logic signed [DIST_W-1:0]  eps_s;
    logic                      on_band;
    logic                      is_below;
    t_verdict                  verdict;

    assign out_free = !r_out_valid || o_point.ready;
    assign emit     = out_free && (r_state == S_EMITX || r_state == S_VERT || r_state == S_END);
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    assign o_point.valid          = r_out_valid;
    assign o_point.out_x          = r_ox;
    assign o_point.out_y          = r_oy;
    assign o_point.out_z          = r_oz;
    assign o_point.goes_below     = r_obelow;
    assign o_point.goes_above     = r_oabove;
    assign o_point.is_crossing    = r_ocross;
    assign o_point.end_of_polygon = r_oend;
    assign o_point.verdict        = r_overdict;

    // operands of the current lane and edge direction
    always_comb begin
        case (r_lane)
            2'd0:    cur_c = r_cur.x;
            2'd1:    cur_c = r_cur.y;
            default: cur_c = r_cur.z;
        endcase
        prior_c = r_prior[r_lane];
        first_c = r_first[r_lane];
        a_c     = r_closing ? cur_c : prior_c;
        b_c     = r_closing ? first_c : cur_c;
        da      = r_closing ? r_cur.plane_dist : r_prior_dist;
        db      = r_closing ? r_first_dist : r_cur.plane_dist;
        f       = dist_mag(da);
        s       = SUM_W'(f) + SUM_W'(dist_mag(db));
        diff    = DIFF_W'(b_c) - DIFF_W'(a_c);
        trial   = {r_rem, r_m[DIFF_W-1]};
        ge      = trial >= (SUM_W+1)'(s);
        rnd     = {r_rem, 1'b0} >= (SUM_W+1)'(s);
        qr      = r_q + DIFF_W'(rnd);
        cross_c = r_up ? COORD_W'(DIFF_W'(a_c) + qr) : COORD_W'(DIFF_W'(a_c) - qr);
    end

    // vertex side and polygon verdict
    always_comb begin
        eps_s    = DIST_W'(i_tol);
        on_band  = (r_cur.plane_dist > -eps_s) && (r_cur.plane_dist < eps_s);
        is_below = r_cur.plane_dist < 0;
        if (r_any_b && r_any_a) begin
            verdict = VERDICT_SPLIT;
        end else if (!r_any_b && !r_any_a) begin
            verdict = VERDICT_COPLANAR;
        end else if (r_any_b) begin
            verdict = VERDICT_BELOW;
        end else begin
            verdict = VERDICT_ABOVE;
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_point.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= 1'b0;
            r_any_b     <= 1'b0;
            r_any_a     <= 1'b0;
            r_closing   <= 1'b0;
            r_lane      <= '0;
            r_cnt       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_closing <= 1'b0;
                    r_lane    <= '0;
                    if (r_seen && crosses(r_prior_dist, r_cur.plane_dist, i_tol)) begin
                        r_state <= S_SETUP;
                    end else begin
                        r_state <= S_VERT;
                    end
                end
                S_SETUP: begin
                    r_cnt   <= CNT_W'(DIFF_W - 1);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DLOAD;
                    end
                end
                S_DLOAD: begin
                    r_cnt   <= CNT_W'(DIFF_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    if (r_lane == 2'd2) begin
                        r_state <= S_EMITX;
                    end else begin
                        r_lane  <= r_lane + 1'b1;
                        r_state <= S_SETUP;
                    end
                end
                S_EMITX: begin
                    if (out_free) begin
                        r_state <= r_closing ? S_END : S_VERT;
                    end
                end
                S_VERT: begin
                    if (out_free) begin
                        r_seen <= 1'b1;
                        if (!on_band && is_below) begin
                            r_any_b <= 1'b1;
                        end
                        if (!on_band && !is_below) begin
                            r_any_a <= 1'b1;
                        end
                        r_state <= r_cur.final_vertex ? S_CLOSE : S_IDLE;
                    end
                end
                S_CLOSE: begin
                    r_closing <= 1'b1;
                    r_lane    <= '0;
                    if (crosses(r_cur.plane_dist, r_first_dist, i_tol)) begin
                        r_state <= S_SETUP;
                    end else begin
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (out_free) begin
                        r_seen  <= 1'b0;
                        r_any_b <= 1'b0;
                        r_any_a <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath: serial product, restoring division, stored points, result word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_rec;
        end
        if (r_state == S_SETUP) begin
            r_up <= !diff[DIFF_W-1];
            r_m  <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            r_p  <= '0;
        end
        if (r_state == S_MUL) begin
            r_p <= (r_p << 1) + (r_m[DIFF_W-1] ? PROD_W'(f) : PROD_W'(0));
            r_m <= r_m << 1;
        end
        if (r_state == S_DLOAD) begin
            r_rem <= SUM_W'(r_p[PROD_W-1:DIFF_W]);
            r_m   <= r_p[DIFF_W-1:0];
            r_q   <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem <= ge ? SUM_W'(trial - (SUM_W+1)'(s)) : SUM_W'(trial);
            r_q   <= {r_q[DIFF_W-2:0], ge};
            r_m   <= r_m << 1;
        end
        if (r_state == S_RND) begin
            r_cp[r_lane] <= cross_c;
        end
        if (r_state == S_EMITX && out_free) begin
            r_ox       <= r_cp[0];
            r_oy       <= r_cp[1];
            r_oz       <= r_cp[2];
            r_obelow   <= 1'b1;
            r_oabove   <= 1'b1;
            r_ocross   <= 1'b1;
            r_oend     <= 1'b0;
            r_overdict <= VERDICT_SPLIT;
        end
        if (r_state == S_VERT && out_free) begin
            r_ox       <= r_cur.x;
            r_oy       <= r_cur.y;
            r_oz       <= r_cur.z;
            r_obelow   <= on_band || is_below;
            r_oabove   <= on_band || !is_below;
            r_ocross   <= 1'b0;
            r_oend     <= 1'b0;
            r_overdict <= VERDICT_SPLIT;
            if (!r_seen) begin
                r_first[0]   <= r_cur.x;
                r_first[1]   <= r_cur.y;
                r_first[2]   <= r_cur.z;
                r_first_dist <= r_cur.plane_dist;
            end
            r_prior[0]   <= r_cur.x;
            r_prior[1]   <= r_cur.y;
            r_prior[2]   <= r_cur.z;
            r_prior_dist <= r_cur.plane_dist;
        end
        if (r_state == S_END && out_free) begin
            r_ox       <= '0;
            r_oy       <= '0;
            r_oz       <= '0;
            r_obelow   <= 1'b0;
            r_oabove   <= 1'b0;
            r_ocross   <= 1'b0;
            r_oend     <= 1'b1;
            r_overdict <= verdict;
        end
    end
endmodule

[hw/rtl/polygon_plane_splitter_core.sv]
// top level of the polygon plane splitter: config registers, front, queue, back
// depends on pps_pkg, pps_vert_if, pps_point_if, pps_front, pps_queue, pps_back
//
// port      dir  handshake       word
// i_vert    in   valid/ready     vert_x, vert_y, vert_z, final_vertex
// o_point   out  valid/ready     out_x, out_y, out_z, side flags, end, verdict
// i_cfg_*   in   write enable    register index, write data
//
// front: product stage, distance stage; a vertex is taken only if the first is empty
// back: IDLE, PLAN and VERT per vertex, CLOSE and END for the closing word, and each
// crossing runs SETUP, MUL, DLOAD, DIV, RND in the shared serial multiply/divide unit
// a 4-entry queue lets the front keep taking vertices while the back divides
// synchronous active-low reset; no clearing pass, the block is ready after reset
module polygon_plane_splitter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pps_vert_if.sink                       i_vert,
    pps_point_if.source                    o_point,
    input  logic                           i_cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pps_pkg::*;

    t_cfg      r_cfg;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    t_vert_rec f_rec;
    t_vert_rec q_rec;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_x     <= '0;
            r_cfg.normal_y     <= '0;
            r_cfg.normal_z     <= NORM_W'(65536);
            r_cfg.plane_offset <= '0;
            r_cfg.tol          <= TOL_W'(65);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NORMAL_X: r_cfg.normal_x     <= i_cfg_data[NORM_W-1:0];
                CFG_NORMAL_Y: r_cfg.normal_y     <= i_cfg_data[NORM_W-1:0];
                CFG_NORMAL_Z: r_cfg.normal_z     <= i_cfg_data[NORM_W-1:0];
                CFG_OFFSET:   r_cfg.plane_offset <= i_cfg_data[COORD_W-1:0];
                CFG_TOL:      r_cfg.tol          <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    pps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vert  (i_vert),
        .o_push  (push),
        .o_rec   (f_rec),
        .i_full  (full)
    );

    pps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (f_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_rec   (q_rec),
        .o_empty (empty)
    );

    pps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tol   (r_cfg.tol),
        .i_rec   (q_rec),
        .i_empty (empty),
        .o_pop   (pop),
        .o_point (o_point)
    );
endmodule

[hw/rtl/pps_checker.sv]
// port-level checks on the splitter output words, bound to the top level
// depends on polygon_plane_splitter_core_defines.svh
`include "polygon_plane_splitter_core_defines.svh"

module pps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_goes_below,
    input logic       i_goes_above,
    input logic       i_is_crossing,
    input logic       i_end_of_polygon,
    input logic [1:0] i_verdict
);
    // a stalled word stays offered
    `PPS_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid, "output word dropped")
    // verdict only rides on the closing word
    `PPS_ASSERT_NOW(a_verdict, i_out_valid && !i_end_of_polygon, i_verdict == 2'd0, "stray verdict")
    // closing word carries no side flags
    `PPS_ASSERT_NOW(a_end, i_out_valid && i_end_of_polygon, !i_goes_below && !i_goes_above && !i_is_crossing, "flags on closing word")
    // crossings go to both sides
    `PPS_ASSERT_NOW(a_cross, i_out_valid && i_is_crossing, i_goes_below && i_goes_above, "crossing not on both sides")
endmodule

bind polygon_plane_splitter_core pps_checker u_pps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_point.valid),
    .i_out_ready      (o_point.ready),
    .i_goes_below     (o_point.goes_below),
    .i_goes_above     (o_point.goes_above),
    .i_is_crossing    (o_point.is_crossing),
    .i_end_of_polygon (o_point.end_of_polygon),
    .i_verdict        (o_point.verdict)
);

[tb/tb.sv]
// self-checking bench for polygon_plane_splitter_core: random and directed polygons,
// point-level prediction in a scoreboard class, random idling and one long output stall
// depends on pps_pkg, pps_vert_if, pps_point_if and the core
module tb;
    import pps_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    // one emitted point or verdict word
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               below;
        logic               above;
        logic               crossing;
        logic               last;
        t_verdict           verdict;
    } t_point_word;

    // tracks plane settings and polygon state, predicts the words of each vertex
    class split_tracker;
        logic signed [17:0] nx, ny, nz;
        logic signed [31:0] offset;
        logic [15:0]        tol;
        logic signed [31:0] first_pt [3];
        logic signed [31:0] prior_pt [3];
        logic signed [47:0] first_d, prior_d;
        bit                 started, saw_below, saw_above;
        t_point_word        pending_points [$];
        int                 fails;

        function void clear();
            nx = 0; ny = 0; nz = 18'sd65536; offset = 0; tol = 16'd65;
            started = 0; saw_below = 0; saw_above = 0;
            first_d = 0; prior_d = 0; fails = 0;
            foreach (first_pt[i]) begin
                first_pt[i] = 0;
                prior_pt[i] = 0;
            end
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_NORMAL_X: nx = val[17:0];
                CFG_NORMAL_Y: ny = val[17:0];
                CFG_NORMAL_Z: nz = val[17:0];
                CFG_OFFSET:   offset = val;
                CFG_TOL:      tol = val[15:0];
                default: ;
            endcase
        endfunction

        // append a predicted word
        function void queue_word(t_point_word w);
            pending_points = {pending_points, w};
        endfunction

        // signed distance N.p + d, floor of the Q2.16 scaling
        function logic signed [47:0] plane_distance(logic signed [31:0] p [3]);
            logic signed [63:0] acc;
            acc = nx * p[0] + ny * p[1] + nz * p[2];
            acc = (acc >>> 16) + offset;
            return acc[47:0];
        endfunction

        function logic [63:0] magnitude(logic signed [63:0] v);
            return v < 0 ? -v : v;
        endfunction

        function bit straddles(logic signed [47:0] da, logic signed [47:0] db);
            bit opp;
            opp = (da < 0 && db > 0) || (da > 0 && db < 0);
            return opp && magnitude(da) > tol && magnitude(db) > tol;
        endfunction

        // point on a->b where the distance crosses zero, rounded away from a on ties
        function t_point_word edge_crossing(logic signed [31:0] a [3], logic signed [47:0] da,
                                            logic signed [31:0] b [3], logic signed [47:0] db);
            t_point_word w;
            logic [63:0]  fa, s, m;
            logic [127:0] prod, q, rem;
            logic signed [31:0] r [3];
            fa = magnitude(da);
            s = fa + magnitude(db);
            for (int i = 0; i < 3; i++) begin
                m = (b[i] >= a[i]) ? 64'(longint'(b[i]) - longint'(a[i]))
                                   : 64'(longint'(a[i]) - longint'(b[i]));
                prod = {64'd0, m} * {64'd0, fa};
                q = prod / {64'd0, s};
                rem = prod - q * {64'd0, s};
                if (rem >= {64'd0, s} - rem) q = q + 1;
                r[i] = (b[i] >= a[i]) ? a[i] + q[31:0] : a[i] - q[31:0];
            end
            w = '{r[0], r[1], r[2], 1'b1, 1'b1, 1'b1, 1'b0, VERDICT_SPLIT};
            return w;
        endfunction

        // accepted vertex: queue the words it causes
        function void note_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z, logic last);
            logic signed [31:0] cur [3];
            logic signed [47:0] d;
            t_point_word w;
            t_verdict v;
            cur[0] = x; cur[1] = y; cur[2] = z;
            d = plane_distance(cur);
            if (started && straddles(prior_d, d))
                queue_word(edge_crossing(prior_pt, prior_d, cur, d));
            w = '{x, y, z, 1'b0, 1'b0, 1'b0, 1'b0, VERDICT_SPLIT};
            if (d > -$signed({1'b0, tol}) && d < $signed({1'b0, tol})) begin
                w.below = 1; w.above = 1;
            end else if (d < 0) begin
                w.below = 1; saw_below = 1;
            end else begin
                w.above = 1; saw_above = 1;
            end
            queue_word(w);
            if (!started) begin
                first_pt = cur; first_d = d; started = 1;
            end
            prior_pt = cur;
            prior_d = d;
            if (last) begin
                if (straddles(d, first_d))
                    queue_word(edge_crossing(cur, d, first_pt, first_d));
                if (saw_below && saw_above) v = VERDICT_SPLIT;
                else if (!saw_below && !saw_above) v = VERDICT_COPLANAR;
                else if (saw_below) v = VERDICT_BELOW;
                else v = VERDICT_ABOVE;
                queue_word('{0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1, v});
                started = 0; saw_below = 0; saw_above = 0;
            end
        endfunction

        function void field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
                fails++;
            end
        endfunction

        // compare an accepted word with the oldest expectation
        function void check_point(t_point_word got);
            t_point_word want;
            if (pending_points.size() == 0) begin
                $display("%0t unexpected word: expected none actual x=%h y=%h z=%h end=%b",
                         $time, got.x, got.y, got.z, got.last);
                fails++;
                return;
            end
            want = pending_points.pop_front();
            field("out_x", want.x, got.x);
            field("out_y", want.y, got.y);
            field("out_z", want.z, got.z);
            field("goes_below", want.below, got.below);
            field("goes_above", want.above, got.above);
            field("is_crossing", want.crossing, got.crossing);
            field("end_of_polygon", want.last, got.last);
            field("verdict", want.verdict, got.verdict);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    bit   calm;
    bit   hold_req;
    bit   hold_done;
    int   hold_left;
    int   cycles;
    split_tracker sb;

    pps_vert_if  vin();
    pps_point_if vout();

    polygon_plane_splitter_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vert    (vin),
        .o_point   (vout),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // output ready: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            vout.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            vout.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            vout.ready <= calm || ($urandom_range(0, 99) >= 22);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_point_word got;
        if (i_rst_n && vout.valid && vout.ready) begin
            got = '{vout.out_x, vout.out_y, vout.out_z, vout.goes_below, vout.goes_above,
                    vout.is_crossing, vout.end_of_polygon, t_verdict'(vout.verdict)};
            sb.check_point(got);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_plane(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] d, logic [31:0] eps);
        write_reg(CFG_NORMAL_X, x);
        write_reg(CFG_NORMAL_Y, y);
        write_reg(CFG_NORMAL_Z, z);
        write_reg(CFG_OFFSET, d);
        write_reg(CFG_TOL, eps);
    endtask

    // offer one vertex word and wait for it to be taken
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic last);
        while (!calm && $urandom_range(0, 99) < 22) begin
            vin.valid <= 1'b0;
            @(posedge i_clk);
        end
        vin.valid        <= 1'b1;
        vin.vert_x       <= x;
        vin.vert_y       <= y;
        vin.vert_z       <= z;
        vin.final_vertex <= last;
        do @(posedge i_clk); while (!vin.ready);
        sb.note_vertex(x, y, z, last);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 200)) - 100;
            default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    task automatic random_polygons(int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                send_vertex(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
            sent += len;
        end
    endtask

    // let every expected word arrive, then a short quiet spell
    task automatic drain();
        @(posedge i_clk);
        vin.valid <= 1'b0;
        while (sb.pending_points.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    localparam logic signed [31:0] UNIT = 32'sd65536;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;

    initial begin
        sb = new();
        sb.clear();
        i_clk = 0; i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        calm = 0; hold_req = 0; hold_done = 0; hold_left = 0; cycles = 0;
        vin.valid = 0; vin.vert_x = 0; vin.vert_y = 0; vin.vert_z = 0;
        vin.final_vertex = 0;
        vout.ready = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: on plane, one-sided singles, split triangle, band edges, extremes
        send_vertex(0, 0, 0, 1);
        send_vertex(CMIN, CMAX, -UNIT, 1);
        send_vertex(CMAX, CMIN, UNIT, 1);
        send_vertex(0, 0, -2 * UNIT, 0);
        send_vertex(2 * UNIT, 0, 2 * UNIT, 0);
        send_vertex(0, 2 * UNIT, 2 * UNIT, 1);
        send_vertex(UNIT, UNIT, 64, 0);
        send_vertex(UNIT, -UNIT, 65, 0);
        send_vertex(-UNIT, -UNIT, -65, 0);
        send_vertex(-UNIT, UNIT, -64, 1);
        send_vertex(CMIN, CMIN, CMIN, 0);
        send_vertex(CMAX, CMAX, CMAX, 1);
        send_vertex(3, -7, -5 * UNIT, 0);
        send_vertex(-9, 4, 3 * UNIT, 1);
        drain();

        // default plane, random polygons
        random_polygons(30);
        drain();

        // random plane, long output hold-off while input keeps coming
        set_plane($urandom_range(0, 18'h3ffff), $urandom_range(0, 18'h3ffff),
                  $urandom_range(0, 18'h3ffff), $signed($urandom_range(0, 32'h0040_0000))
                  - 32'sh0020_0000, $urandom_range(0, 2000));
        @(posedge i_clk);
        hold_req <= 1'b1;
        random_polygons(35);
        drain();

        // extreme plane settings
        set_plane(32'h2_0000, 32'h1_ffff, 32'h2_0000, 32'h7fff_ffff, 16'hffff);
        random_polygons(15);
        drain();
        set_plane(32'h1_ffff, 32'h2_0000, 32'h1_ffff, 32'h8000_0000, 16'h0000);
        random_polygons(15);
        drain();

        // unit-ish normal, zero band, no idling
        set_plane(32'h0_b505, 32'h0_0000, 32'h3_4afb, 32'h0000_8000, 16'h0000);
        calm = 1;
        random_polygons(35);
        drain();

        if (sb.fails == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
